// ----- sv/masked_byte_pattern_scan_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the scan unit modules.
// Each module that uses them has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MBPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Types, codes and the hex digit decoder shared by the scan unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    // Pattern text characters
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_WILD  = 8'h3F;
    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] ASCII_9  = 8'h39;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LF = 8'h66;
    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_UF = 8'h46;

    localparam logic [7:0] MASK_HIGH = 8'hF0;
    localparam logic [7:0] MASK_LOW  = 8'h0F;

    // Match tally codes
    localparam logic [1:0] TALLY_NONE = 2'd0;
    localparam logic [1:0] TALLY_ONE  = 2'd1;
    localparam logic [1:0] TALLY_MANY = 2'd2;

    // Pattern parser state
    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_BAD  = 2'd2,
        PH_FULL = 2'd3
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NONE  = 2'd1,
        ST_AMBIG = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    // Command from the parser front to the scan back
    typedef struct packed {
        logic       is_data;
        logic [7:0] data_byte;
        logic       last;
        logic       clear_pat;
        logic       append;
        logic [7:0] value;
        logic [7:0] mask;
        logic       set_bad;
        logic       close;
        logic       uniq;
    } cmd_t;

    // Compare stage to tally stage
    typedef struct packed {
        logic        data;
        logic        last;
        logic        hit;
        logic        clr;
        logic        empty_bad;
        logic        uniq;
        logic [63:0] cand;
    } s1_t;

    // One result item
    typedef struct packed {
        logic [63:0] addr;
        status_t     status;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'h0;
        case (c) inside
            [ASCII_0:ASCII_9]:   h.value = 4'(c - ASCII_0);
            [ASCII_LA:ASCII_LF]: h.value = 4'(c - ASCII_LA + 8'd10);
            [ASCII_UA:ASCII_UF]: h.value = 4'(c - ASCII_UA + 8'd10);
            default:             h.ok = 1'b0;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mbps_fifo.sv -----
// ----------------------------------------------------------------------------
// mbps_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scan_unit_defines.svh"

module mbps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    `MBPS_ASSERT_IMP(a_no_push_full, push, !full, "push into a full queue")
    `MBPS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= (AW+1)'(DEPTH), "queue count above depth")

endmodule

`default_nettype wire

// ----- sv/mbps_front.sv -----
// ----------------------------------------------------------------------------
// mbps_front
// Parses pattern text into masked pattern bytes and issues scan commands.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scan_unit_defines.svh"

module mbps_front #(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        mode,
    input  wire logic [7:0]  pattern_char,
    input  wire logic        unique_mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output mbps_pkg::cmd_t   cmd
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    mbps_pkg::phase_t phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       pval_reg, pval_next;
    logic [7:0]       pmask_reg, pmask_next;
    logic             closed_reg, closed_next;

    mbps_pkg::phase_t eff_phase;
    logic [LEN_W-1:0] eff_len;
    logic [7:0]       eff_pval;
    logic [7:0]       eff_pmask;
    logic             start_new;
    logic             is_end;
    logic             is_space;
    logic             is_wild;
    mbps_pkg::hex_t   hex;
    mbps_pkg::phase_t commit_phase;

    // Classify the character and apply a pending pattern restart
    always_comb
    begin
        is_end    = (pattern_char == mbps_pkg::CH_END);
        is_space  = (pattern_char == mbps_pkg::CH_SPACE);
        is_wild   = (pattern_char == mbps_pkg::CH_WILD);
        hex       = mbps_pkg::hex_decode(pattern_char);
        start_new = !mode && !is_end && closed_reg;
        eff_phase = start_new ? mbps_pkg::PH_HIGH : phase_reg;
        eff_len   = start_new ? '0 : len_reg;
        eff_pval  = start_new ? 8'h00 : pval_reg;
        eff_pmask = start_new ? 8'h00 : pmask_reg;
        commit_phase = (eff_len == LEN_W'(MAX_PATTERN - 1)) ?
                       mbps_pkg::PH_FULL : mbps_pkg::PH_HIGH;
    end

    // Next parser state
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        pval_next   = pval_reg;
        pmask_next  = pmask_reg;
        closed_next = closed_reg;
        if (accept && !mode)
        begin
            if (is_end)
            begin
                closed_next = 1'b1;
                if (phase_reg == mbps_pkg::PH_LOW)
                begin
                    len_next   = len_reg + 1'b1;
                    phase_next = commit_phase;
                    pval_next  = 8'h00;
                    pmask_next = 8'h00;
                end
            end
            else
            begin
                closed_next = 1'b0;
                phase_next  = eff_phase;
                len_next    = eff_len;
                pval_next   = eff_pval;
                pmask_next  = eff_pmask;
                unique case (eff_phase) inside
                    mbps_pkg::PH_HIGH:
                    begin
                        if (is_wild)
                        begin
                            pval_next  = 8'h00;
                            pmask_next = 8'h00;
                            phase_next = mbps_pkg::PH_LOW;
                        end
                        else if (hex.ok)
                        begin
                            pval_next  = {hex.value, 4'h0};
                            pmask_next = mbps_pkg::MASK_HIGH;
                            phase_next = mbps_pkg::PH_LOW;
                        end
                        else if (!is_space)
                        begin
                            phase_next = mbps_pkg::PH_BAD;
                        end
                    end
                    mbps_pkg::PH_LOW:
                    begin
                        if (is_space || is_wild || hex.ok)
                        begin
                            len_next   = eff_len + 1'b1;
                            phase_next = commit_phase;
                            pval_next  = 8'h00;
                            pmask_next = 8'h00;
                        end
                        else
                        begin
                            phase_next = mbps_pkg::PH_BAD;
                        end
                    end
                    mbps_pkg::PH_BAD, mbps_pkg::PH_FULL:
                    begin
                        phase_next = eff_phase;
                    end
                    default:
                    begin
                        phase_next = eff_phase;
                    end
                endcase
            end
        end
    end

    // Build the command for the back part
    always_comb
    begin
        cmd           = '0;
        cmd.is_data   = mode;
        cmd.data_byte = data_byte;
        cmd.last      = last_byte;
        if (!mode)
        begin
            if (is_end)
            begin
                cmd.close  = 1'b1;
                cmd.uniq   = unique_mode;
                cmd.append = (phase_reg == mbps_pkg::PH_LOW);
                cmd.value  = pval_reg;
                cmd.mask   = pmask_reg;
            end
            else
            begin
                cmd.clear_pat = start_new;
                unique case (eff_phase) inside
                    mbps_pkg::PH_HIGH:
                    begin
                        cmd.set_bad = !is_space && !is_wild && !hex.ok;
                    end
                    mbps_pkg::PH_LOW:
                    begin
                        if (is_space || is_wild)
                        begin
                            cmd.append = 1'b1;
                            cmd.value  = eff_pval;
                            cmd.mask   = eff_pmask;
                        end
                        else if (hex.ok)
                        begin
                            cmd.append = 1'b1;
                            cmd.value  = eff_pval | {4'h0, hex.value};
                            cmd.mask   = eff_pmask | mbps_pkg::MASK_LOW;
                        end
                        else
                        begin
                            cmd.set_bad = 1'b1;
                        end
                    end
                    mbps_pkg::PH_BAD, mbps_pkg::PH_FULL:
                    begin
                        cmd.set_bad = 1'b0;
                    end
                    default:
                    begin
                        cmd.set_bad = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mbps_pkg::PH_HIGH;
            len_reg    <= '0;
            pval_reg   <= 8'h00;
            pmask_reg  <= 8'h00;
            closed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            pval_reg   <= pval_next;
            pmask_reg  <= pmask_next;
            closed_reg <= closed_next;
        end
    end

    `MBPS_ASSERT_IMP(a_full_at_max, phase_reg == mbps_pkg::PH_FULL,
        len_reg == LEN_W'(MAX_PATTERN), "parser full below the pattern limit")

endmodule

`default_nettype wire

// ----- sv/mbps_back.sv -----
// ----------------------------------------------------------------------------
// mbps_back
// Holds the pattern and the byte window, compares under mask and reports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scan_unit_defines.svh"

module mbps_back #(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire mbps_pkg::cmd_t cmd,
    output logic                cmd_pop,
    input  wire logic [63:0]    region_base,
    input  wire logic           res_full,
    output logic                res_push,
    output mbps_pkg::res_t      res
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Window and pattern are stored newest first, so lane j lines up
    logic [7:0]             win_reg   [MAX_PATTERN];
    logic [7:0]             pval_reg  [MAX_PATTERN];
    logic [7:0]             pmask_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pvld_reg, pvld_next;
    logic [LEN_W-1:0]       plen_reg, plen_next;
    logic                   bad_reg, bad_next;
    logic                   uniq_reg, uniq_next;
    logic [63:0]            seen_reg, seen_next;
    logic                   s1_valid_reg;
    mbps_pkg::s1_t          s1_reg, s1_next;
    logic [1:0]             tally_reg, tally_next;
    logic [63:0]            off_reg, off_next;

    logic [7:0]             lane_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_ok;
    logic [63:0]            seen_inc;
    logic [63:0]            plen_ext;
    logic                   stall;
    logic                   s1_fire;
    logic [1:0]             tally_hit;
    logic [63:0]            off_hit;

    assign stall   = s1_valid_reg && s1_reg.data && s1_reg.last && res_full;
    assign cmd_pop = cmd_valid && !stall;
    assign s1_fire = s1_valid_reg && !stall;

    // Compare every lane of the shifted window under the mask
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (j == 0)
            begin
                lane_byte[j] = cmd.data_byte;
            end
            else
            begin
                lane_byte[j] = win_reg[j-1];
            end
            lane_ok[j] = !pvld_reg[j] ||
                         (((lane_byte[j] ^ pval_reg[j]) & pmask_reg[j]) == 8'h00);
        end
    end

    // Update the scan state and fill the compare stage
    always_comb
    begin
        seen_inc  = seen_reg + 64'd1;
        plen_ext  = {{(64-LEN_W){1'b0}}, plen_reg};
        pvld_next = pvld_reg;
        plen_next = plen_reg;
        bad_next  = bad_reg;
        uniq_next = uniq_reg;
        seen_next = seen_reg;

        s1_next.data      = cmd.is_data;
        s1_next.last      = cmd.last;
        s1_next.clr       = !cmd.is_data && cmd.close;
        s1_next.empty_bad = (plen_reg == '0) || bad_reg;
        s1_next.uniq      = uniq_reg;
        s1_next.cand      = seen_inc - plen_ext;
        s1_next.hit       = cmd.is_data && (plen_reg != '0) && !bad_reg &&
                            (seen_inc >= plen_ext) && (&lane_ok);

        if (cmd.is_data)
        begin
            seen_next = cmd.last ? 64'd0 : seen_inc;
        end
        else
        begin
            if (cmd.clear_pat)
            begin
                pvld_next = '0;
                plen_next = '0;
                bad_next  = 1'b0;
            end
            if (cmd.set_bad)
            begin
                bad_next = 1'b1;
            end
            if (cmd.append)
            begin
                for (int j = 0; j < MAX_PATTERN; j++)
                begin
                    if (j == 0)
                    begin
                        pvld_next[j] = 1'b1;
                    end
                    else
                    begin
                        pvld_next[j] = pvld_reg[j-1];
                    end
                end
                plen_next = plen_reg + 1'b1;
            end
            if (cmd.close)
            begin
                uniq_next = cmd.uniq;
                seen_next = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg     <= '0;
            plen_reg     <= '0;
            bad_reg      <= 1'b0;
            uniq_reg     <= 1'b0;
            seen_reg     <= 64'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                pvld_reg <= pvld_next;
                plen_reg <= plen_next;
                bad_reg  <= bad_next;
                uniq_reg <= uniq_next;
                seen_reg <= seen_next;
            end
            if (!stall)
            begin
                s1_valid_reg <= cmd_pop;
            end
        end
    end

    // Shift the window, the pattern and the compare stage payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.is_data)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                win_reg[j] <= lane_byte[j];
            end
        end
        if (cmd_pop && !cmd.is_data && cmd.append)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (j == 0)
                begin
                    pval_reg[j]  <= cmd.value;
                    pmask_reg[j] <= cmd.mask;
                end
                else
                begin
                    pval_reg[j]  <= pval_reg[j-1];
                    pmask_reg[j] <= pmask_reg[j-1];
                end
            end
        end
        if (cmd_pop)
        begin
            s1_reg <= s1_next;
        end
    end

    // Tally matches and form the result on the last region byte
    always_comb
    begin
        tally_hit = tally_reg;
        off_hit   = off_reg;
        if (s1_reg.hit)
        begin
            if (tally_reg == mbps_pkg::TALLY_NONE)
            begin
                tally_hit = mbps_pkg::TALLY_ONE;
                off_hit   = s1_reg.cand;
            end
            else
            begin
                tally_hit = mbps_pkg::TALLY_MANY;
            end
        end

        res.addr   = 64'd0;
        res.status = mbps_pkg::ST_FOUND;
        if (s1_reg.empty_bad)
        begin
            res.status = mbps_pkg::ST_BAD;
        end
        else if (tally_hit == mbps_pkg::TALLY_NONE)
        begin
            res.status = mbps_pkg::ST_NONE;
        end
        else if (s1_reg.uniq && (tally_hit == mbps_pkg::TALLY_MANY))
        begin
            res.status = mbps_pkg::ST_AMBIG;
        end
        else
        begin
            res.addr = region_base + off_hit;
        end

        res_push   = s1_valid_reg && s1_reg.data && s1_reg.last && !res_full;
        tally_next = tally_reg;
        off_next   = off_reg;
        if (s1_fire)
        begin
            if (s1_reg.clr || (s1_reg.data && s1_reg.last))
            begin
                tally_next = mbps_pkg::TALLY_NONE;
                off_next   = 64'd0;
            end
            else
            begin
                tally_next = tally_hit;
                off_next   = off_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= mbps_pkg::TALLY_NONE;
            off_reg   <= 64'd0;
        end
        else
        begin
            tally_reg <= tally_next;
            off_reg   <= off_next;
        end
    end

    `MBPS_ASSERT_IMP(a_len_tracks_valid, 1'b1,
        $countones(pvld_reg) == int'(plen_reg), "pattern length out of step with valid lanes")
    `MBPS_ASSERT_NEXT(a_stall_holds, stall,
        s1_valid_reg && $stable(s1_reg), "compare stage moved while stalled")
    `MBPS_ASSERT_IMP(a_tally_code, 1'b1,
        tally_reg != 2'd3, "match tally holds an unused code")

endmodule

`default_nettype wire

// ----- sv/masked_byte_pattern_scan_unit.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit
// Byte signature scanner with nibble wildcards over a streamed region.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): mode 0 carries one pattern text character,
//   pattern_char 0 closes the pattern and latches unique_mode; mode 1 carries
//   one region byte, last_byte marks the end of the region.
//   Result queue (empty/pop): one result per region, match_address and status
//   (found, no match, ambiguous, bad or empty pattern).
//   Config channel (cfg_valid/cfg_ready): writes region_base; cfg_ready is
//   always high. Write it only while no item is in flight.
//   Throughput: one item per cycle while full is low, pattern characters and
//   region bytes alike; the window compare checks all pattern lanes in parallel.
//   A last region byte's result passes through the command queue, the
//   compare stage, then the tally into the result queue.
//   When the receiver stalls, results collect in the result queue, then the
//   compare stage holds, then the command queue fills and full rises.
//   Reset clears the pattern, the scan state and region_base; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan_unit #(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        mode,
    input  wire logic [7:0]  pattern_char,
    input  wire logic        unique_mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      match_address,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data
);

    localparam int CMD_W   = $bits(mbps_pkg::cmd_t);
    localparam int RES_W   = $bits(mbps_pkg::res_t);
    localparam int CMD_DEP = 4;
    localparam int RES_DEP = 2;

    logic [63:0]    region_base_reg;
    logic           accept;
    mbps_pkg::cmd_t front_cmd;
    mbps_pkg::cmd_t back_cmd;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           res_full;
    logic           res_push;
    mbps_pkg::res_t back_res;
    mbps_pkg::res_t out_res;

    assign cfg_ready     = 1'b1;
    assign accept        = push && !full;
    assign match_address = out_res.addr;
    assign status        = out_res.status;

    // Hold the region base address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            region_base_reg <= cfg_data;
        end
    end

    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .pattern_char (pattern_char),
        .unique_mode  (unique_mode),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cmd          (front_cmd)
    );

    mbps_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEP)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    mbps_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (!cmd_empty),
        .cmd         (back_cmd),
        .cmd_pop     (cmd_pop),
        .region_base (region_base_reg),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (back_res)
    );

    mbps_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEP)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ----- tb/masked_byte_pattern_scan_unit_test.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit_test
// Self-checking bench for the nibble-wildcard byte signature scanner. A
// driver pushes pattern text and region bytes from a stimulus queue, and a
// scan predictor updated on every input transfer computes the
// expected region results. A monitor pops results and compares each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module masked_byte_pattern_scan_unit_test;

    localparam int MAX_BYTES = 64;

    typedef struct {
        logic       mode;
        logic [7:0] ch;
        logic       uniq;
        logic [7:0] data;
        logic       last;
    } scan_input_t;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        mode = 1'b0;
    logic [7:0]  pattern_char = 8'h00;
    logic        unique_mode = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] match_address;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = 64'h0;

    // Stimulus and bookkeeping
    scan_input_t    scan_inputs_q[$];
    mbps_pkg::res_t expected_reports[$];
    int             queued_total = 0;
    int             accepted_total = 0;
    int             mismatch_count = 0;
    int             sender_idle_pct = 0;
    int             receiver_idle_pct = 0;
    int             receiver_hold_cycles = 0;

    // Scan predictor state
    logic [7:0]       pat_val [MAX_BYTES] = '{default: 8'h00};
    logic [7:0]       pat_msk [MAX_BYTES] = '{default: 8'h00};
    int               pat_len = 0;
    mbps_pkg::phase_t parse_ph = mbps_pkg::PH_HIGH;
    logic [7:0]       part_val = 8'h00;
    logic [7:0]       part_msk = 8'h00;
    logic [7:0]       win [MAX_BYTES] = '{default: 8'h00};
    logic [63:0]      seen = 64'h0;
    logic [63:0]      first_off = 64'h0;
    logic [1:0]       tally = mbps_pkg::TALLY_NONE;
    logic             uniq_latched = 1'b0;
    logic             closed = 1'b0;
    logic [63:0]      scan_base = 64'h0;

    // Generator copy of the last generated pattern, used to plant matches
    logic [7:0]  gen_val [MAX_BYTES];
    logic [7:0]  gen_msk [MAX_BYTES];
    int          gen_len = 0;

    masked_byte_pattern_scan_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .pattern_char  (pattern_char),
        .unique_mode   (unique_mode),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty         (empty),
        .pop           (pop),
        .match_address (match_address),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------
    function automatic int digit_of(input logic [7:0] c);
        if (c >= mbps_pkg::ASCII_0 && c <= mbps_pkg::ASCII_9)
            return int'(c - mbps_pkg::ASCII_0);
        if (c >= mbps_pkg::ASCII_LA && c <= mbps_pkg::ASCII_LF)
            return int'(c - mbps_pkg::ASCII_LA) + 10;
        if (c >= mbps_pkg::ASCII_UA && c <= mbps_pkg::ASCII_UF)
            return int'(c - mbps_pkg::ASCII_UA) + 10;
        return -1;
    endfunction

    task automatic clear_scan();
        foreach (win[i])
            win[i] = 8'h00;
        seen = 64'h0;
        first_off = 64'h0;
        tally = mbps_pkg::TALLY_NONE;
    endtask

    // Commit the partial byte and move the parser on
    task automatic store_partial();
        if (pat_len < MAX_BYTES)
        begin
            pat_val[pat_len] = part_val;
            pat_msk[pat_len] = part_msk;
            pat_len++;
        end
        part_val = 8'h00;
        part_msk = 8'h00;
        parse_ph = (pat_len >= MAX_BYTES) ? mbps_pkg::PH_FULL : mbps_pkg::PH_HIGH;
    endtask

    task automatic scan_take_char(input logic [7:0] c, input logic u);
        int d;
        d = digit_of(c);
        // Terminator: flush a lone nibble, latch the mode, restart the scan
        if (c == mbps_pkg::CH_END)
        begin
            if (parse_ph == mbps_pkg::PH_LOW)
                store_partial();
            uniq_latched = u;
            clear_scan();
            closed = 1'b1;
            return;
        end
        // First character after a terminator starts a fresh pattern
        if (closed)
        begin
            closed = 1'b0;
            pat_len = 0;
            parse_ph = mbps_pkg::PH_HIGH;
            part_val = 8'h00;
            part_msk = 8'h00;
        end
        if (parse_ph == mbps_pkg::PH_BAD || parse_ph == mbps_pkg::PH_FULL)
            return;
        if (parse_ph == mbps_pkg::PH_HIGH)
        begin
            if (c == mbps_pkg::CH_SPACE)
                return;
            part_val = 8'h00;
            part_msk = 8'h00;
            if (c != mbps_pkg::CH_WILD)
            begin
                if (d < 0)
                begin
                    parse_ph = mbps_pkg::PH_BAD;
                    return;
                end
                part_val = {d[3:0], 4'h0};
                part_msk = mbps_pkg::MASK_HIGH;
            end
            parse_ph = mbps_pkg::PH_LOW;
            return;
        end
        // Low nibble
        if (c == mbps_pkg::CH_SPACE || c == mbps_pkg::CH_WILD)
        begin
            store_partial();
            return;
        end
        if (d < 0)
        begin
            parse_ph = mbps_pkg::PH_BAD;
            return;
        end
        part_val = part_val | {4'h0, d[3:0]};
        part_msk = part_msk | mbps_pkg::MASK_LOW;
        store_partial();
    endtask

    task automatic scan_take_byte(input logic [7:0] d, input logic last);
        mbps_pkg::res_t rep;
        bit             hit;
        // Shift the window and compare at the newest position
        for (int i = MAX_BYTES - 1; i > 0; i--)
            win[i] = win[i - 1];
        win[0] = d;
        seen = seen + 64'd1;
        if (pat_len > 0 && parse_ph != mbps_pkg::PH_BAD && seen >= 64'(pat_len))
        begin
            hit = 1'b1;
            for (int i = 0; i < pat_len; i++)
                if (((win[pat_len - 1 - i] ^ pat_val[i]) & pat_msk[i]) != 8'h00)
                    hit = 1'b0;
            if (hit)
            begin
                if (tally == mbps_pkg::TALLY_NONE)
                begin
                    first_off = seen - 64'(pat_len);
                    tally = mbps_pkg::TALLY_ONE;
                end
                else
                    tally = mbps_pkg::TALLY_MANY;
            end
        end
        if (!last)
            return;
        // End of region: form the verdict
        rep.addr = 64'h0;
        if (pat_len == 0 || parse_ph == mbps_pkg::PH_BAD)
            rep.status = mbps_pkg::ST_BAD;
        else if (tally == mbps_pkg::TALLY_NONE)
            rep.status = mbps_pkg::ST_NONE;
        else if (uniq_latched && tally == mbps_pkg::TALLY_MANY)
            rep.status = mbps_pkg::ST_AMBIG;
        else
        begin
            rep.status = mbps_pkg::ST_FOUND;
            rep.addr = scan_base + first_off;
        end
        expected_reports.push_back(rep);
        clear_scan();
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] c, input logic u);
        scan_input_t it;
        it.mode = 1'b0;
        it.ch = c;
        it.uniq = u;
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        scan_inputs_q.push_back(it);
        queued_total++;
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic last);
        scan_input_t it;
        it.mode = 1'b1;
        it.ch = 8'($urandom);
        it.uniq = 1'($urandom);
        it.data = d;
        it.last = last;
        scan_inputs_q.push_back(it);
        queued_total++;
    endtask

    task automatic queue_text(input string s, input logic u);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], 1'($urandom));
        queue_char(mbps_pkg::CH_END, u);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
            return mbps_pkg::ASCII_0 + 8'(d);
        return (($urandom & 1) ? mbps_pkg::ASCII_LA : mbps_pkg::ASCII_UA) + 8'(d) - 8'd10;
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (digit_of(c) >= 0 || c == mbps_pkg::CH_SPACE || c == mbps_pkg::CH_WILD);
        return c;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(60, 70);
    endfunction

    // Emit a pattern as text; a bad character follows byte bad_at if it is >= 0
    task automatic queue_pattern(input int nbytes, input logic u, input int bad_at);
        int         kind;
        int         gap;
        bit         lone;
        logic [7:0] v;
        logic [7:0] m;
        gen_len = 0;
        repeat ($urandom_range(0, 2))
            queue_char(mbps_pkg::CH_SPACE, 1'($urandom));
        for (int i = 0; i < nbytes; i++)
        begin
            kind = $urandom_range(99);
            m = (kind < 50) ? 8'hFF :
                (kind < 70) ? mbps_pkg::MASK_HIGH :
                (kind < 85) ? mbps_pkg::MASK_LOW : 8'h00;
            v = 8'($urandom) & m;
            if (i < MAX_BYTES)
            begin
                gen_val[i] = v;
                gen_msk[i] = m;
                gen_len = i + 1;
            end
            lone = (m == mbps_pkg::MASK_HIGH || m == 8'h00) && $urandom_range(1);
            queue_char((m[7:4] != 4'h0) ? hex_char(v[7:4]) : mbps_pkg::CH_WILD,
                       1'($urandom));
            if (!lone)
                queue_char((m[3:0] != 4'h0) ? hex_char(v[3:0]) : mbps_pkg::CH_WILD,
                           1'($urandom));
            gap = $urandom_range(0, 2);
            if (lone && gap == 0 && i != nbytes - 1)
                gap = 1;
            repeat (gap)
                queue_char(mbps_pkg::CH_SPACE, 1'($urandom));
            if (i == bad_at)
                queue_char(bad_char(), 1'($urandom));
        end
        queue_char(mbps_pkg::CH_END, u);
    endtask

    // Region of random bytes, with planted pattern copies now and then
    task automatic queue_region();
        logic [7:0] region[$];
        int         len;
        int         copies;
        int         pos;
        int         k;
        copies = (gen_len > 0) ? $urandom_range(0, 2) : 0;
        len = (copies > 0) ? gen_len + $urandom_range(0, 12) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++)
        begin
            if (gen_len > 0 && $urandom_range(1))
            begin
                k = $urandom_range(0, gen_len - 1);
                region.push_back(gen_val[k] | (8'($urandom) & ~gen_msk[k]));
            end
            else
                region.push_back(8'($urandom));
        end
        repeat (copies)
        begin
            pos = $urandom_range(0, len - gen_len);
            for (int j = 0; j < gen_len; j++)
                region[pos + j] = (gen_val[j] & gen_msk[j]) | (8'($urandom) & ~gen_msk[j]);
        end
        for (int i = 0; i < len; i++)
            queue_byte(region[i], i == len - 1);
    endtask

    // Loose characters and bytes with no structure
    task automatic queue_noise();
        int r;
        repeat ($urandom_range(1, 6))
        begin
            r = $urandom_range(99);
            if (r < 35)
                queue_char(8'($urandom), 1'($urandom));
            else if (r < 65)
                queue_char(hex_char(4'($urandom)), 1'($urandom));
            else
                queue_byte(8'($urandom), $urandom_range(99) < 30);
        end
    endtask

    task automatic queue_random_traffic(input int count);
        int target;
        int r;
        int len;
        target = queued_total + count;
        while (queued_total < target)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                queue_pattern(pick_length(), 1'($urandom), -1);
                repeat ($urandom_range(1, 3))
                    queue_region();
            end
            else if (r < 80)
                queue_region();
            else if (r < 92)
                queue_noise();
            else
            begin
                len = pick_length();
                queue_pattern(len, 1'($urandom), $urandom_range(0, len - 1));
                queue_region();
            end
        end
    endtask

    // Hold off until every item went in and every verdict came out
    task automatic wait_until_idle();
        while (accepted_total != queued_total || expected_reports.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_region_base(input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_base = value;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued items, predict on each transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        scan_input_t nxt;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (mode)
                    scan_take_byte(data_byte, last_byte);
                else
                    scan_take_char(pattern_char, unique_mode);
                accepted_total++;
            end
            if (!push || !full)
            begin
                if (scan_inputs_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = scan_inputs_q.pop_front();
                    push <= 1'b1;
                    mode <= nxt.mode;
                    pattern_char <= nxt.ch;
                    unique_mode <= nxt.uniq;
                    data_byte <= nxt.data;
                    last_byte <= nxt.last;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Count down a long receiver stall
    always @(posedge clk)
    begin
        if (receiver_hold_cycles > 0)
            receiver_hold_cycles--;
    end

    // ------------------------------------------------------------------
    // Monitor: pop verdicts and compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mbps_pkg::res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("unexpected result, status", 64'(status), 64'h0);
                else
                begin
                    want = expected_reports.pop_front();
                    if (match_address !== want.addr)
                        report_mismatch("match_address", match_address, want.addr);
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                end
            end
            if (receiver_hold_cycles > 0)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Slow sender, very slow receiver
        sender_idle_pct = 36;
        receiver_idle_pct = 82;

        // Empty pattern
        queue_byte(8'h00, 1'b1);
        // Leading and repeated spaces, nibble wildcard, lone trailing digit;
        // two hits in unique mode give ambiguous
        queue_text(" Ab  ?F 5", 1'b1);
        queue_byte(8'hAB, 1'b0);
        queue_byte(8'h3F, 1'b0);
        queue_byte(8'h5C, 1'b0);
        queue_byte(8'hAB, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h59, 1'b1);
        // Bad character
        queue_text("G", 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_until_idle();

        // Address wraps past the top of the space
        write_region_base(64'hFFFF_FFFF_FFFF_FFFF);
        queue_text("e9", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hE9, 1'b0);
        queue_byte(8'hE9, 1'b1);
        queue_random_traffic(200);
        wait_until_idle();

        // Very slow sender, slow receiver
        sender_idle_pct = 82;
        receiver_idle_pct = 36;
        write_region_base({$urandom, $urandom});
        queue_random_traffic(210);
        wait_until_idle();

        // Full rate; a long receiver stall lets the block back up
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_region_base(64'h0);
        repeat (6)
            queue_byte(8'($urandom), 1'b1);
        queue_random_traffic(110);
        receiver_hold_cycles = 400;
        wait_until_idle();

        write_region_base({1'b1, 31'($urandom), $urandom});
        queue_random_traffic(100);
        wait_until_idle();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_fifo.sv
sv/mbps_front.sv
sv/mbps_back.sv
sv/masked_byte_pattern_scan_unit.sv
tb/masked_byte_pattern_scan_unit_test.sv
